### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int PRIO_W  = 16;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_SPARE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      cell_op_type op;
      entry_type   item;
   } cell_ctl_type;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast item, and takes its own entry, its left or right neighbor's entry, or the item.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                occupied,
   input  logic                behind_left,
   input  spq_pkg::entry_type  entry_left,
   input  spq_pkg::entry_type  entry_right,
   output logic                behind,
   output spq_pkg::entry_type  entry_ff,
   output spq_pkg::entry_type  entry_in
);
   import spq_pkg::*;

   // entry stays ahead of the new item when it is held and not greater
   assign behind = occupied && (entry_ff.prio <= ctl.item.prio);

   // select next entry
   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (behind) begin
               entry_in = entry_ff;
            end else if (behind_left) begin
               entry_in = ctl.item;
            end else begin
               entry_in = entry_left;
            end
         end
         CELL_REMOVE: entry_in = entry_right;
         default:     entry_in = entry_ff;
      endcase
   end

   // hold slot payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/stable_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded priority queue kept sorted in a chain of shifting slots.
// ----------------------------------------------------------------------------
// For each request beat (insert, remove head, or status query) every slot
// compares its priority with the new item in parallel and shifts toward the
// tail on insert or toward the head on remove, so a new beat is taken every
// cycle while the result register is free or being drained. One result beat
// follows each request in the next cycle. Equal priorities leave in arrival
// order; an insert into a full queue is dropped and flagged, a remove on an
// empty queue is flagged with zero data.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic signed [spq_pkg::DATA_W-1:0] req_item_data,
   input  logic signed [spq_pkg::PRIO_W-1:0] req_item_priority,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_removed_data,
   output logic [1:0]                       rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_head_data,
   output logic                             rsp_queue_empty,
   output logic [spq_pkg::CNT_W-1:0]        rsp_entry_count
);
   import spq_pkg::*;

   logic                    accept;
   cmd_type                 cmd;
   logic                    full;
   logic                    empty;
   cell_ctl_type            ctl;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DEPTH-1:0]        occupied;
   logic [DEPTH-1:0]        behind;
   entry_type               entry_ff [DEPTH];
   entry_type               entry_in [DEPTH];
   status_type              status_in;
   logic signed [DATA_W-1:0] removed_in;

   logic                    rsp_valid_ff;
   logic signed [DATA_W-1:0] removed_ff, head_ff;
   status_type              status_ff;
   logic                    empty_ff;
   logic [CNT_W-1:0]        rcount_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // decode the beat into a chain operation
   always_comb begin
      ctl.item.data = req_item_data;
      ctl.item.prio = req_item_priority;
      ctl.op        = CELL_HOLD;
      status_in     = STAT_OK;
      removed_in    = '0;
      count_in      = count_ff;
      if (accept) begin
         unique case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  ctl.op     = CELL_REMOVE;
                  removed_in = entry_ff[0].data;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            default: ctl.op = CELL_HOLD;
         endcase
      end
   end

   // build the chain of slots
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .behind_left (1'b1),
            .entry_left  (ctl.item),
            .entry_right (entry_ff[i+1]),
            .behind      (behind[i]),
            .entry_ff    (entry_ff[i]),
            .entry_in    (entry_in[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .behind_left (behind[i-1]),
            .entry_left  (entry_ff[i-1]),
            .entry_right (entry_ff[i]),
            .behind      (behind[i]),
            .entry_ff    (entry_ff[i]),
            .entry_in    (entry_in[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .behind_left (behind[i-1]),
            .entry_left  (entry_ff[i-1]),
            .entry_right (entry_ff[i+1]),
            .behind      (behind[i]),
            .entry_ff    (entry_ff[i]),
            .entry_in    (entry_in[i])
         );
      end
   end

   // advance count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
         head_ff    <= (count_in != '0) ? entry_in[0].data : '0;
         empty_ff   <= (count_in == '0);
         rcount_ff  <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_removed_data = removed_ff;
   assign rsp_status       = status_ff;
   assign rsp_head_data    = head_ff;
   assign rsp_queue_empty  = empty_ff;
   assign rsp_entry_count  = rcount_ff;

endmodule

### verif/stable_sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top_test
// Self-checking bench for the stable sorted priority queue.
// ----------------------------------------------------------------------------
// A short table of directed request beats covers the empty and full corners,
// the extreme data words and priorities, ties at both ends of the priority
// range and the spare command code. Random fill and drain phases follow, with
// plenty of tied priorities, so the queue swings between empty and full many
// times. A local copy of the queue predicts each result beat that the table
// does not write out, and each one is compared field by field as it leaves
// the block. Both handshakes idle at random. One long receiver stall backs
// the block up, and one sender pause lets the result stream run dry.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top_test;

   import spq_pkg::*;

   localparam int          RANDOM_ITEMS = 1626;
   localparam int          PHASE_ITEMS  = 80;
   localparam int          LONG_HOLD    = 150;
   localparam int          STALL_LIMIT  = 1000;
   localparam int          TAIL_CYCLES  = 8;
   localparam int          SHOWN_ERRORS = 10;

   typedef struct packed {
      logic signed [DATA_W-1:0] removed_data;
      status_type               status;
      logic signed [DATA_W-1:0] head_data;
      logic                     queue_empty;
      logic [CNT_W-1:0]         entry_count;
   } queue_reply_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
      logic                     typed;
      queue_reply_type          reply;
   } plan_row_type;

   // directed beats; rows with typed set carry their result written out
   localparam int PLAN_ROWS = 24;
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{CMD_QUERY,  32'h0,        16'h0,    1'b1, '{32'h0, STAT_OK,    32'h0, 1'b1, 5'd0}},
      '{CMD_REMOVE, 32'h12345678, 16'h0,    1'b1, '{32'h0, STAT_EMPTY, 32'h0, 1'b1, 5'd0}},
      '{CMD_SPARE,  32'hdeadbeef, 16'h1234, 1'b1, '{32'h0, STAT_OK,    32'h0, 1'b1, 5'd0}},
      '{CMD_INSERT, 32'h7fffffff, 16'h7fff, 1'b1,
        '{32'h0, STAT_OK, 32'h7fffffff, 1'b0, 5'd1}},
      '{CMD_INSERT, 32'h80000000, 16'h8000, 1'b1,
        '{32'h0, STAT_OK, 32'h80000000, 1'b0, 5'd2}},
      '{CMD_INSERT, 32'h5,        16'h0,    1'b0, '0},
      '{CMD_INSERT, 32'h6,        16'h0,    1'b0, '0},
      '{CMD_INSERT, 32'hffffffff, 16'hffff, 1'b0, '0},
      '{CMD_INSERT, 32'h8,        16'h8000, 1'b0, '0},
      '{CMD_INSERT, 32'h9,        16'h7fff, 1'b0, '0},
      '{CMD_INSERT, 32'h0,        16'h0,    1'b0, '0},
      '{CMD_INSERT, 32'h55555555, 16'h5555, 1'b0, '0},
      '{CMD_INSERT, 32'haaaaaaaa, 16'haaaa, 1'b0, '0},
      '{CMD_INSERT, 32'h13,       16'h1,    1'b0, '0},
      '{CMD_INSERT, 32'h14,       16'hffff, 1'b0, '0},
      '{CMD_INSERT, 32'h15,       16'h0,    1'b0, '0},
      '{CMD_INSERT, 32'h16,       16'h2,    1'b0, '0},
      '{CMD_INSERT, 32'h17,       16'hfffe, 1'b0, '0},
      '{CMD_INSERT, 32'h18,       16'h0,    1'b0, '0},
      '{CMD_INSERT, 32'h19,       16'h8000, 1'b0, '0},
      '{CMD_QUERY,  32'h0,        16'h0,    1'b0, '0},
      '{CMD_REMOVE, 32'h0,        16'h0,    1'b1,
        '{32'h80000000, STAT_OK, 32'h8, 1'b0, 5'd15}},
      '{CMD_REMOVE, 32'h0,        16'h0,    1'b0, '0},
      '{CMD_SPARE,  32'h0,        16'h0,    1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   cmd_type                  req_cmd = CMD_QUERY;
   logic signed [DATA_W-1:0] req_item_data = '0;
   logic signed [PRIO_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_removed_data;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_head_data;
   logic                     rsp_queue_empty;
   logic [CNT_W-1:0]         rsp_entry_count;

   // typed expectation that travels with the request beat on offer
   logic                     row_typed = 1'b0;
   queue_reply_type          row_reply = '0;

   // local copy of the queue contents
   entry_type                held_slots [DEPTH];
   int                       held_count = 0;

   queue_reply_type          pending_replies [$];
   int                       failures = 0;
   int                       replies_checked = 0;
   int                       idle_cycles = 0;
   bit                       burst_mode = 1'b0;
   bit                       long_hold_done = 1'b0;

   stable_sorted_priority_queue_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_data  (rsp_removed_data),
      .rsp_status        (rsp_status),
      .rsp_head_data     (rsp_head_data),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the local queue and return the result it produces.
   function automatic queue_reply_type apply_queue_op(input cmd_type cmd,
                                                      input logic signed [DATA_W-1:0] data,
                                                      input logic signed [PRIO_W-1:0] prio);
      queue_reply_type reply;
      int              slot;
      reply = '0;
      reply.status = STAT_OK;
      case (cmd)
         CMD_INSERT: begin
            if (held_count >= DEPTH) begin
               reply.status = STAT_FULL;
            end else begin
               // new entry goes behind every entry of lower or equal priority
               slot = 0;
               while (slot < held_count && held_slots[slot].prio <= prio) slot++;
               for (int i = held_count; i > slot; i--) held_slots[i] = held_slots[i-1];
               held_slots[slot].data = data;
               held_slots[slot].prio = prio;
               held_count++;
            end
         end
         CMD_REMOVE: begin
            if (held_count == 0) begin
               reply.status = STAT_EMPTY;
            end else begin
               reply.removed_data = held_slots[0].data;
               for (int i = 1; i < held_count; i++) held_slots[i-1] = held_slots[i];
               held_count--;
            end
         end
         default: ;
      endcase
      reply.head_data   = (held_count > 0) ? held_slots[0].data : '0;
      reply.queue_empty = (held_count == 0);
      reply.entry_count = CNT_W'(held_count);
      return reply;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void log_failure(input string msg);
      if (failures < SHOWN_ERRORS) $display("ERROR at %0t: %s", $realtime, msg);
      failures++;
   endfunction

   // Offer one request beat, hold it until accepted, then sometimes idle for a while.
   task automatic offer_request(input plan_row_type row);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_cmd           <= row.cmd;
      req_item_data     <= row.data;
      req_item_priority <= row.prio;
      row_typed         <= row.typed;
      row_reply         <= row.reply;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted result beat has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Predict on each accepted request beat, check each accepted result beat.
   always @(posedge clock) begin : check_proc
      queue_reply_type predicted;
      queue_reply_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = apply_queue_op(req_cmd, req_item_data, req_item_priority);
            pending_replies.push_back(row_typed ? row_reply : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (pending_replies.size() == 0) begin
               log_failure("result beat with no request waiting");
            end else begin
               want = pending_replies.pop_front();
               if (rsp_removed_data !== want.removed_data || rsp_status !== want.status ||
                   rsp_head_data !== want.head_data || rsp_queue_empty !== want.queue_empty ||
                   rsp_entry_count !== want.entry_count) begin
                  log_failure($sformatf(
                     {"removed %0d/%0d status %0d/%0d head %0d/%0d ",
                      "empty %0b/%0b count %0d/%0d (exp/got)"},
                     want.removed_data, rsp_removed_data, want.status, rsp_status,
                     want.head_data, rsp_head_data, want.queue_empty, rsp_queue_empty,
                     want.entry_count, rsp_entry_count));
               end
            end
         end
      end
   end

   // End the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Drive result-side ready: random runs, plus one long hold to back the block up.
   initial begin : ready_proc
      int unsigned hold_len;
      forever begin
         if (!long_hold_done && replies_checked >= 400) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            hold_len = pick_gap();
            if (hold_len == 0) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 24)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (hold_len) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus_proc
      plan_row_type row;
      int unsigned  roll;
      bit           fill_phase;
      // hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // walk the directed table
      for (int n = 0; n < PLAN_ROWS; n++) offer_request(directed_plan[n]);
      drain_results();

      // random fill and drain phases
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain_results();
         fill_phase = ((n / PHASE_ITEMS) % 2) == 0;
         row = '0;
         roll = $urandom_range(0, 99);
         if (roll < 3) row.cmd = CMD_SPARE;
         else if (roll < 10) row.cmd = CMD_QUERY;
         else if (roll < (fill_phase ? 70 : 35)) row.cmd = CMD_INSERT;
         else row.cmd = CMD_REMOVE;
         row.data = $urandom;
         // favor a few nearby priorities so ties are common
         roll = $urandom_range(0, 99);
         if (roll < 45) row.prio = PRIO_W'($signed($urandom_range(0, 4)) - 2);
         else if (roll < 55) row.prio = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         else row.prio = PRIO_W'($urandom_range(0, 65535));
         offer_request(row);
      end

      // wait for the last result beats, then let the block settle
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_sorted_priority_queue_top.sv
verif/stable_sorted_priority_queue_top_test.sv
